>>> sv/tmwl_pkg.sv
// ----------------------------------------------------------------------------
// Triangle mesh warp lookup package
// Shared sizes, register indexes, beat types and triangle codes.
// ----------------------------------------------------------------------------
package tmwl_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 128;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_MAP  = 1'b1;

  localparam logic [15:0]        INV_STEP_RESET  = 16'd4096;
  localparam logic [7:0]         GRID_COLS_RESET = 8'd128;
  localparam logic [7:0]         GRID_ROWS_RESET = 8'd128;
  localparam logic signed [13:0] OFFSET_RESET    = 14'sd0;

  typedef enum logic [2:0] {
    REG_INV_STEP_X   = 3'd0,
    REG_INV_STEP_Y   = 3'd1,
    REG_GRID_COLS    = 3'd2,
    REG_GRID_ROWS    = 3'd3,
    REG_OUT_OFFSET_X = 3'd4,
    REG_OUT_OFFSET_Y = 3'd5
  } reg_index_t;

  // Which triangle of a cell the pixel falls in
  typedef enum logic [1:0] {
    TRI_ODD_LO  = 2'd0,
    TRI_ODD_HI  = 2'd1,
    TRI_EVEN_HI = 2'd2,
    TRI_EVEN_LO = 2'd3
  } tri_t;

  typedef struct packed {
    logic               mode;
    logic [14:0]        entry_index;
    logic signed [19:0] point_u;
    logic signed [19:0] point_v;
    logic [11:0]        pixel_x;
    logic [11:0]        pixel_y;
  } item_t;

  typedef struct packed {
    logic signed [15:0] mapped_x;
    logic signed [15:0] mapped_y;
    logic               outside_grid;
  } result_t;

endpackage

>>> sv/triangle_mesh_warp_lookup.sv
// ----------------------------------------------------------------------------
// Triangle mesh warp lookup
// Maps screen pixels to source pixels through a staggered triangular mesh.
// ----------------------------------------------------------------------------
// One beat (a mesh point load or a pixel map) is taken every clock; busy is
// always low. A map beat gives its result on done exactly ten cycles after
// start, for one cycle, and the receiver must take it then. The ten stages
// are the two scale multipliers, row resolve, cell resolve, triangle and
// weight select with the row base multiply, vertex addressing, the mesh
// read, vertex differences, the weight multipliers, the sum and the
// round/offset/saturate. The mesh is held twice so that three vertices are
// read per clock; a load writes both copies at the addressing stage, so
// loads and maps act in the order they were started.
module triangle_mesh_warp_lookup #(
  parameter int MaxColumns = tmwl_pkg::MAX_COLUMNS,
  parameter int MaxRows    = tmwl_pkg::MAX_ROWS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tmwl_pkg::item_t   item,
  output logic              done,
  output tmwl_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int Depth = (MaxRows + 1) * (MaxColumns + 1);
  localparam int AW    = $clog2(Depth);
  localparam int RW    = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int CW    = $clog2(MaxColumns);

  // configuration
  logic [15:0]        inv_step_x, inv_step_y;
  logic [7:0]         grid_cols, grid_rows;
  logic signed [13:0] out_offset_x, out_offset_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_step_x   <= tmwl_pkg::INV_STEP_RESET;
      inv_step_y   <= tmwl_pkg::INV_STEP_RESET;
      grid_cols    <= tmwl_pkg::GRID_COLS_RESET;
      grid_rows    <= tmwl_pkg::GRID_ROWS_RESET;
      out_offset_x <= tmwl_pkg::OFFSET_RESET;
      out_offset_y <= tmwl_pkg::OFFSET_RESET;
    end else if (cfg_we) begin
      unique case (tmwl_pkg::reg_index_t'(cfg_index))
        tmwl_pkg::REG_INV_STEP_X:   inv_step_x   <= cfg_data;
        tmwl_pkg::REG_INV_STEP_Y:   inv_step_y   <= cfg_data;
        tmwl_pkg::REG_GRID_COLS:    grid_cols    <= cfg_data[7:0];
        tmwl_pkg::REG_GRID_ROWS:    grid_rows    <= cfg_data[7:0];
        tmwl_pkg::REG_OUT_OFFSET_X: out_offset_x <= cfg_data[13:0];
        tmwl_pkg::REG_OUT_OFFSET_Y: out_offset_y <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // clamped grid size
  logic [15:0] cols_eff, rows_eff, cols_last, n1;
  logic [AW-1:0] n1_a;

  always_comb begin
    cols_eff = {8'd0, grid_cols};
    if (grid_cols == 8'd0) cols_eff = 16'd1;
    else if ({8'd0, grid_cols} > 16'(MaxColumns)) cols_eff = 16'(MaxColumns);
    rows_eff = {8'd0, grid_rows};
    if (grid_rows == 8'd0) rows_eff = 16'd1;
    else if ({8'd0, grid_rows} > 16'(MaxRows)) rows_eff = 16'(MaxRows);
  end

  assign cols_last = cols_eff - 16'd1;
  assign n1        = cols_eff + 16'd1;
  assign n1_a      = AW'(n1);
  assign busy      = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------- stage 1: scale
  logic               p1_map, p1_load;
  logic [27:0]        p1_sy, p1_sxm;
  logic [AW-1:0]      p1_idx;
  logic signed [19:0] p1_u, p1_v;
  logic [27:0]        sy_mul, sx_mul;

  assign sy_mul = item.pixel_y * inv_step_y;
  assign sx_mul = item.pixel_x * inv_step_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_map  <= 1'b0;
      p1_load <= 1'b0;
    end else begin
      p1_map  <= accept && (item.mode == tmwl_pkg::MODE_MAP);
      // drop loads beyond the store
      p1_load <= accept && (item.mode == tmwl_pkg::MODE_LOAD)
                 && (32'(item.entry_index) < 32'(Depth));
    end
    p1_sy  <= sy_mul;
    p1_sxm <= sx_mul;
    p1_idx <= AW'(item.entry_index);
    p1_u   <= item.point_u;
    p1_v   <= item.point_v;
  end

  // ---------------- stage 2: row
  logic               p2_map, p2_load, p2_odd, p2_out;
  logic [RW-1:0]      p2_j;
  logic [15:0]        p2_fy, p2_h;
  logic [27:0]        p2_sxm;
  logic [AW-1:0]      p2_idx;
  logic signed [19:0] p2_u, p2_v;
  logic               row_over;
  logic [RW-1:0]      j_c;
  logic [16:0]        h_odd;

  assign row_over = {4'd0, p1_sy[27:16]} >= rows_eff;
  assign j_c      = row_over ? RW'(rows_eff - 16'd1) : RW'(p1_sy[27:16]);
  assign h_odd    = (17'h10000 - {1'b0, p1_sy[15:0]}) >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_map  <= 1'b0;
      p2_load <= 1'b0;
    end else begin
      p2_map  <= p1_map;
      p2_load <= p1_load;
    end
    p2_j   <= j_c;
    p2_odd <= j_c[0];
    p2_fy  <= p1_sy[15:0];
    p2_h   <= j_c[0] ? h_odd[15:0] : {1'b0, p1_sy[15:1]};
    p2_out <= row_over;
    p2_sxm <= p1_sxm;
    p2_idx <= p1_idx;
    p2_u   <= p1_u;
    p2_v   <= p1_v;
  end

  // ---------------- stage 3: cell
  logic               p3_map, p3_load, p3_odd, p3_out;
  logic [RW-1:0]      p3_j;
  logic [CW-1:0]      p3_i;
  logic [15:0]        p3_fx, p3_fy, p3_h;
  logic [AW-1:0]      p3_idx;
  logic signed [19:0] p3_u, p3_v;
  logic [28:0]        sx;
  logic               col_over;

  assign sx       = {1'b0, p2_sxm} + {13'd0, p2_h};
  assign col_over = {3'd0, sx[28:16]} >= cols_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_map  <= 1'b0;
      p3_load <= 1'b0;
    end else begin
      p3_map  <= p2_map;
      p3_load <= p2_load;
    end
    p3_i   <= col_over ? CW'(cols_last) : CW'(sx[28:16]);
    p3_fx  <= sx[15:0];
    p3_out <= p2_out || col_over;
    p3_j   <= p2_j;
    p3_odd <= p2_odd;
    p3_fy  <= p2_fy;
    p3_h   <= p2_h;
    p3_idx <= p2_idx;
    p3_u   <= p2_u;
    p3_v   <= p2_v;
  end

  // ---------------- stage 4: triangle, weights, row base
  logic               p4_map, p4_load, p4_out;
  tmwl_pkg::tri_t     p4_tri;
  logic signed [18:0] p4_w1, p4_w2;
  logic [AW-1:0]      p4_base;
  logic [AW-1:0]      p4_idx;
  logic signed [19:0] p4_u, p4_v;

  logic signed [18:0] fx19, fy19, fx_mod, w1_c, w2_c;
  logic [16:0]        fxy_sum;
  logic               i_first, i_last;
  tmwl_pkg::tri_t     tri_c;
  logic [AW-1:0]      base_c;
  localparam logic signed [18:0] One = 19'sd65536;

  assign fx19    = $signed({3'b000, p3_fx});
  assign fy19    = $signed({3'b000, p3_fy});
  assign fx_mod  = (fx19 - $signed({3'b000, p3_h})) <<< 1;
  assign fxy_sum = {1'b0, p3_fx} + {1'b0, p3_fy};
  assign i_first = (p3_i == '0);
  assign i_last  = (16'(p3_i) == cols_last);
  assign base_c  = p3_j * n1_a + p3_i;

  always_comb begin
    if (p3_odd) begin
      if (fxy_sum <= 17'h10000) begin
        tri_c = tmwl_pkg::TRI_ODD_LO;
        w1_c  = i_first ? fx_mod : fx19;
        w2_c  = fy19;
      end else begin
        tri_c = tmwl_pkg::TRI_ODD_HI;
        w1_c  = One - fy19;
        w2_c  = One - (i_last ? fx_mod : fx19);
      end
    end else begin
      if (p3_fx >= p3_fy) begin
        tri_c = tmwl_pkg::TRI_EVEN_HI;
        w1_c  = One - (i_last ? fx_mod : fx19);
        w2_c  = fy19;
      end else begin
        tri_c = tmwl_pkg::TRI_EVEN_LO;
        w1_c  = One - fy19;
        w2_c  = i_first ? fx_mod : fx19;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_map  <= 1'b0;
      p4_load <= 1'b0;
    end else begin
      p4_map  <= p3_map;
      p4_load <= p3_load;
    end
    p4_tri  <= tri_c;
    p4_w1   <= w1_c;
    p4_w2   <= w2_c;
    p4_base <= base_c;
    p4_out  <= p3_out;
    p4_idx  <= p3_idx;
    p4_u    <= p3_u;
    p4_v    <= p3_v;
  end

  // ---------------- stage 5: vertex addresses
  logic               p5_map, p5_load, p5_out;
  logic [AW-1:0]      p5_a, p5_b, p5_c;
  logic signed [18:0] p5_w1, p5_w2;
  logic [AW-1:0]      p5_idx;
  logic signed [19:0] p5_u, p5_v;
  logic [AW-1:0]      a_c, b_c, c_c;

  always_comb begin
    unique case (p4_tri)
      tmwl_pkg::TRI_ODD_LO: begin
        a_c = p4_base;
        b_c = p4_base + AW'(1);
        c_c = p4_base + n1_a;
      end
      tmwl_pkg::TRI_ODD_HI: begin
        a_c = p4_base + n1_a + AW'(1);
        b_c = p4_base + AW'(1);
        c_c = p4_base + n1_a;
      end
      tmwl_pkg::TRI_EVEN_HI: begin
        a_c = p4_base + AW'(1);
        b_c = p4_base;
        c_c = p4_base + n1_a + AW'(1);
      end
      default: begin
        a_c = p4_base + n1_a;
        b_c = p4_base;
        c_c = p4_base + n1_a + AW'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_map  <= 1'b0;
      p5_load <= 1'b0;
    end else begin
      p5_map  <= p4_map;
      p5_load <= p4_load;
    end
    p5_a   <= a_c;
    p5_b   <= b_c;
    p5_c   <= c_c;
    p5_w1  <= p4_w1;
    p5_w2  <= p4_w2;
    p5_out <= p4_out;
    p5_idx <= p4_idx;
    p5_u   <= p4_u;
    p5_v   <= p4_v;
  end

  // ---------------- stage 6: mesh read, two copies for three vertices
  logic [39:0] mesh_ab [Depth];
  logic [39:0] mesh_c  [Depth];
  logic [39:0] rd_a, rd_b, rd_c;

  always_ff @(posedge clk) begin
    if (p5_load) begin
      mesh_ab[p5_idx] <= {p5_u, p5_v};
      mesh_c[p5_idx]  <= {p5_u, p5_v};
    end
    rd_a <= mesh_ab[p5_a];
    rd_b <= mesh_ab[p5_b];
    rd_c <= mesh_c[p5_c];
  end

  logic               p6_map, p6_out;
  logic signed [18:0] p6_w1, p6_w2;

  always_ff @(posedge clk) begin
    if (rst) p6_map <= 1'b0;
    else     p6_map <= p5_map;
    p6_out <= p5_out;
    p6_w1  <= p5_w1;
    p6_w2  <= p5_w2;
  end

  // ---------------- stage 7: differences
  logic signed [19:0] ua, va, ub, vb, uc, vc;
  logic signed [20:0] dub_c, duc_c, dvb_c, dvc_c;

  assign ua    = $signed(rd_a[39:20]);
  assign va    = $signed(rd_a[19:0]);
  assign ub    = $signed(rd_b[39:20]);
  assign vb    = $signed(rd_b[19:0]);
  assign uc    = $signed(rd_c[39:20]);
  assign vc    = $signed(rd_c[19:0]);
  assign dub_c = ub - ua;
  assign duc_c = uc - ua;
  assign dvb_c = vb - va;
  assign dvc_c = vc - va;

  logic               p7_map, p7_out;
  logic signed [19:0] p7_ua, p7_va;
  logic signed [20:0] p7_dub, p7_duc, p7_dvb, p7_dvc;
  logic signed [18:0] p7_w1, p7_w2;

  always_ff @(posedge clk) begin
    if (rst) p7_map <= 1'b0;
    else     p7_map <= p6_map;
    p7_out <= p6_out;
    p7_ua  <= ua;
    p7_va  <= va;
    p7_dub <= dub_c;
    p7_duc <= duc_c;
    p7_dvb <= dvb_c;
    p7_dvc <= dvc_c;
    p7_w1  <= p6_w1;
    p7_w2  <= p6_w2;
  end

  // ---------------- stage 8: weight products
  logic               p8_map, p8_out;
  logic signed [39:0] p8_pub, p8_puc, p8_pvb, p8_pvc;
  logic signed [35:0] p8_au, p8_av;
  logic signed [39:0] pub_c, puc_c, pvb_c, pvc_c;

  assign pub_c = p7_w1 * p7_dub;
  assign puc_c = p7_w2 * p7_duc;
  assign pvb_c = p7_w1 * p7_dvb;
  assign pvc_c = p7_w2 * p7_dvc;

  always_ff @(posedge clk) begin
    if (rst) p8_map <= 1'b0;
    else     p8_map <= p7_map;
    p8_out <= p7_out;
    p8_pub <= pub_c;
    p8_puc <= puc_c;
    p8_pvb <= pvb_c;
    p8_pvc <= pvc_c;
    p8_au  <= {p7_ua, 16'd0};
    p8_av  <= {p7_va, 16'd0};
  end

  // ---------------- stage 9: sum in Q.20
  logic               p9_map, p9_out;
  logic signed [41:0] p9_su, p9_sv;
  logic signed [41:0] su_c, sv_c;

  assign su_c = 42'(p8_au) + 42'(p8_pub) + 42'(p8_puc);
  assign sv_c = 42'(p8_av) + 42'(p8_pvb) + 42'(p8_pvc);

  always_ff @(posedge clk) begin
    if (rst) p9_map <= 1'b0;
    else     p9_map <= p8_map;
    p9_out <= p8_out;
    p9_su  <= su_c;
    p9_sv  <= sv_c;
  end

  // ---------------- stage 10: round, offset, saturate
  function automatic logic signed [15:0] finish(input logic signed [41:0] q,
                                                input logic signed [13:0] off);
    logic signed [41:0] rnd;
    logic signed [21:0] sh;
    logic signed [22:0] r;
    rnd = q + 42'sd524288;
    sh  = 22'(rnd >>> 20);
    r   = 23'(sh) + 23'(off);
    if (r > 23'sd32767)       finish = 16'sd32767;
    else if (r < -23'sd32768) finish = -16'sd32768;
    else                      finish = 16'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= p9_map;
    result.mapped_x     <= finish(p9_su, out_offset_x);
    result.mapped_y     <= finish(p9_sv, out_offset_y);
    result.outside_grid <= p9_out;
  end

  // ---------------- checks
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && item.mode == tmwl_pkg::MODE_MAP, 10))
    else $error("result without a map beat ten cycles earlier");

  a_row_in_grid: assert property (@(posedge clk) disable iff (rst)
    p2_map |-> (16'(p2_j) < rows_eff))
    else $error("row index not clamped");

  a_cell_in_grid: assert property (@(posedge clk) disable iff (rst)
    p3_map |-> (16'(p3_i) <= cols_last))
    else $error("cell index not clamped");

  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(p5_load && p5_map))
    else $error("mesh write and read from one stage slot");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    p5_map |-> (32'(p5_a) < 32'(Depth)) && (32'(p5_b) < 32'(Depth))
               && (32'(p5_c) < 32'(Depth)))
    else $error("vertex address beyond mesh");

endmodule
